>>> rtl/core/pstb_pkg.sv
package pstb_pkg;

    localparam int LEN_W      = 8;
    localparam int WORD_W     = 64;
    localparam int CHAR_W     = 8;
    localparam int UPOS_W     = 5;
    localparam int SLOT_NUM_W = 4;
    localparam int MASK_W     = 16;
    localparam int ROW_W      = 256;
    localparam int CHARS_W    = 2 * WORD_W;

    typedef struct packed {
        logic clear;
        logic reset_run;
        logic store;
        logic rec_zero;
        logic start_str;
        logic eval;
        logic emit_adv;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic ovf;
        logic all_done;
        logic lim_zero;
        logic found;
        logic emit_last;
    } t_sts;

    function automatic logic [CHAR_W-1:0] byte_sel(input logic [CHARS_W-1:0] w,
                                                   input logic [3:0] idx);
        return w[idx*CHAR_W +: CHAR_W];
    endfunction

endpackage

>>> rtl/core/pstb_in_if.sv
interface pstb_in_if;
    import pstb_pkg::*;
    logic                valid;
    logic                ready;
    logic [LEN_W-1:0]    string_length;
    logic [WORD_W-1:0]   chars_low;
    logic [WORD_W-1:0]   chars_high;
    logic                last_string;

    modport source (output valid, string_length, chars_low, chars_high, last_string,
                    input ready);
    modport sink (input valid, string_length, chars_low, chars_high, last_string,
                  output ready);
endinterface

>>> rtl/core/pstb_out_if.sv
interface pstb_out_if;
    import pstb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [CHAR_W-1:0]     unique_char;
    logic [UPOS_W-1:0]     unique_position;
    logic [MASK_W-1:0]     occupied_mask;
    logic [MASK_W-1:0]     continuation_mask;
    logic                  too_many;
    logic                  last_result;

    modport source (output valid, slot_number, unique_char, unique_position,
                    occupied_mask, continuation_mask, too_many, last_result,
                    input ready);
    modport sink (input valid, slot_number, unique_char, unique_position,
                  occupied_mask, continuation_mask, too_many, last_result,
                  output ready);
endinterface

>>> rtl/core/pstb_ram.sv
module pstb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/pstb_ctrl.sv
module pstb_ctrl
    import pstb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid,
    output logic o_out_err
);
    typedef enum logic [2:0] {
        S_CLEAR, S_LOAD, S_START, S_READ, S_EVAL, S_EMIT, S_ERR
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_out_err   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear     = 1'b1;
                o_cmd.reset_run = 1'b1;
                if (i_sts.clr_done) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_in_last) n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.ovf) begin
                    n_state = S_ERR;
                end else if (i_sts.all_done) begin
                    n_state = S_EMIT;
                end else if (i_sts.lim_zero) begin
                    o_cmd.rec_zero = 1'b1;
                end else begin
                    o_cmd.start_str = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state = i_sts.found ? S_START : S_READ;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.emit_adv = 1'b1;
                    if (i_sts.emit_last) n_state = S_CLEAR;
                end
            end
            S_ERR: begin
                o_out_valid = 1'b1;
                o_out_err   = 1'b1;
                if (i_out_ready) n_state = S_CLEAR;
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule

>>> rtl/core/pstb_dp.sv
module pstb_dp
    import pstb_pkg::*;
#(
    parameter int MAX_SLOTS  = 16,
    parameter int SLOT_BYTES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [LEN_W-1:0]      i_len,
    input  logic [WORD_W-1:0]     i_chars_low,
    input  logic [WORD_W-1:0]     i_chars_high,
    output t_sts                  o_sts,
    output logic [SLOT_NUM_W-1:0] o_slot_number,
    output logic [CHAR_W-1:0]     o_unique_char,
    output logic [UPOS_W-1:0]     o_unique_position,
    output logic [MASK_W-1:0]     o_occupied_mask,
    output logic [MASK_W-1:0]     o_continuation_mask,
    output logic                  o_last_result
);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int PW = $clog2(SLOT_BYTES);
    localparam logic [UPOS_W-1:0] CAP = UPOS_W'(SLOT_BYTES);

    logic [CW-1:0]        r_count, r_k, r_s;
    logic                 r_ovf;
    logic [PW:0]          r_pos;
    logic [PW-1:0]        r_clr;
    logic [SW-1:0]        r_order [MAX_SLOTS];
    logic [LEN_W-1:0]     r_slen  [MAX_SLOTS];
    logic [CHAR_W-1:0]    r_uch   [MAX_SLOTS];
    logic [UPOS_W-1:0]    r_upos  [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] r_cont;

    logic [CW-1:0]        ins;
    logic [SW-1:0]        cur_slot;
    logic [UPOS_W-1:0]    cur_lim;
    logic [CHARS_W-1:0]   chars_rd;
    logic [ROW_W-1:0]     row_rd;
    logic [CHAR_W-1:0]    cur_char;
    logic                 seen;
    logic                 bm_we;
    logic [PW-1:0]        bm_addr;
    logic [ROW_W-1:0]     bm_wdata;
    logic [UPOS_W-1:0]    pos_next;

    assign cur_slot = r_order[r_k[SW-1:0]];
    assign cur_lim  = (r_slen[r_k[SW-1:0]] < LEN_W'(SLOT_BYTES)) ?
                      UPOS_W'(r_slen[r_k[SW-1:0]]) : CAP;
    assign cur_char = byte_sel(chars_rd, 4'(r_pos[PW-1:0]));
    assign seen     = row_rd[cur_char];
    assign pos_next = UPOS_W'(r_pos) + UPOS_W'(1);

    assign bm_we    = i_cmd.clear | i_cmd.eval;
    assign bm_addr  = i_cmd.clear ? r_clr : r_pos[PW-1:0];
    assign bm_wdata = i_cmd.clear ? '0 : (row_rd | (ROW_W'(1) << cur_char));

    pstb_ram #(.WIDTH(CHARS_W), .DEPTH(MAX_SLOTS)) u_chars (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store && (r_count < CW'(MAX_SLOTS))),
        .i_waddr (r_count[SW-1:0]),
        .i_wdata ({i_chars_high, i_chars_low}),
        .i_raddr (cur_slot),
        .o_rdata (chars_rd)
    );

    pstb_ram #(.WIDTH(ROW_W), .DEPTH(SLOT_BYTES)) u_seen (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_addr),
        .i_wdata (bm_wdata),
        .i_raddr (r_pos[PW-1:0]),
        .o_rdata (row_rd)
    );

    always_comb begin
        ins = r_count;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if ((CW'(i) < r_count) && (i_len < r_slen[i])) ins = CW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_s     <= '0;
            r_clr   <= '0;
            r_cont  <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.reset_run) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_k     <= '0;
                r_s     <= '0;
                r_cont  <= '0;
                r_pos   <= '0;
            end
            if (i_cmd.clear) begin
                r_clr <= (r_clr == PW'(SLOT_BYTES - 1)) ? '0 : r_clr + PW'(1);
            end
            if (i_cmd.store) begin
                if (r_count < CW'(MAX_SLOTS)) begin
                    r_count <= r_count + CW'(1);
                    r_cont[r_count[SW-1:0]] <= (i_len > LEN_W'(SLOT_BYTES));
                    for (int j = 1; j < MAX_SLOTS; j++) begin
                        if ((CW'(j) > ins) && (CW'(j) <= r_count)) begin
                            r_order[j] <= r_order[j-1];
                            r_slen[j]  <= r_slen[j-1];
                        end
                    end
                    r_order[ins[SW-1:0]] <= r_count[SW-1:0];
                    r_slen[ins[SW-1:0]]  <= i_len;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.rec_zero) begin
                r_uch[cur_slot]  <= '0;
                r_upos[cur_slot] <= '0;
                r_k <= r_k + CW'(1);
            end
            if (i_cmd.start_str) begin
                r_pos <= '0;
            end
            if (i_cmd.eval) begin
                if (o_sts.found) begin
                    r_uch[cur_slot]  <= cur_char;
                    r_upos[cur_slot] <= seen ? pos_next : UPOS_W'(r_pos);
                    r_k <= r_k + CW'(1);
                end else begin
                    r_pos <= r_pos + (PW+1)'(1);
                end
            end
            if (i_cmd.emit_adv) begin
                r_s <= r_s + CW'(1);
            end
        end
    end

    always_comb begin
        o_sts.clr_done  = (r_clr == PW'(SLOT_BYTES - 1));
        o_sts.ovf       = r_ovf;
        o_sts.all_done  = (r_k == r_count);
        o_sts.lim_zero  = (cur_lim == '0);
        o_sts.found     = !seen || (pos_next == cur_lim);
        o_sts.emit_last = (r_s + CW'(1) == r_count);
    end

    always_comb begin
        o_occupied_mask = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            o_occupied_mask[i] = (CW'(i) < r_count);
        end
    end

    assign o_slot_number       = SLOT_NUM_W'(r_s[SW-1:0]);
    assign o_unique_char       = r_uch[r_s[SW-1:0]];
    assign o_unique_position   = r_upos[r_s[SW-1:0]];
    assign o_continuation_mask = MASK_W'(r_cont);
    assign o_last_result       = o_sts.emit_last;
endmodule

>>> rtl/core/prefix_string_table_builder.sv
// Channel | Dir | Word
// i_str   | in  | string_length, chars_low, chars_high, last_string
// o_res   | out | slot_number, unique_char, unique_position, masks, too_many, last_result
//
// A string is stored as it is taken; the length order is updated by a parallel insert.
// After the last string each slot passes a start state, then read and evaluate states per
// position examined (character and bitmap memories both register their read data), then one
// word per slot, or one too_many word on overflow. The bitmap memory is cleared after reset
// and after every run. Input is taken only while loading; results stall on o_res.ready.
module prefix_string_table_builder
    import pstb_pkg::*;
#(
    parameter int MAX_SLOTS  = 16,
    parameter int SLOT_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pstb_in_if.sink    i_str,
    pstb_out_if.source o_res
);
    t_cmd cmd;
    t_sts sts;
    logic in_ready, out_valid, out_err;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [CHAR_W-1:0]     unique_char;
    logic [UPOS_W-1:0]     unique_position;
    logic [MASK_W-1:0]     occupied_mask, continuation_mask;
    logic                  last_result;

    pstb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_str.valid),
        .i_in_last   (i_str.last_string),
        .i_out_ready (o_res.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_out_err   (out_err)
    );

    pstb_dp #(.MAX_SLOTS(MAX_SLOTS), .SLOT_BYTES(SLOT_BYTES)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_len               (i_str.string_length),
        .i_chars_low         (i_str.chars_low),
        .i_chars_high        (i_str.chars_high),
        .o_sts               (sts),
        .o_slot_number       (slot_number),
        .o_unique_char       (unique_char),
        .o_unique_position   (unique_position),
        .o_occupied_mask     (occupied_mask),
        .o_continuation_mask (continuation_mask),
        .o_last_result       (last_result)
    );

    assign i_str.ready             = in_ready;
    assign o_res.valid             = out_valid;
    assign o_res.slot_number       = out_err ? '0 : slot_number;
    assign o_res.unique_char       = out_err ? '0 : unique_char;
    assign o_res.unique_position   = out_err ? '0 : unique_position;
    assign o_res.occupied_mask     = out_err ? '0 : occupied_mask;
    assign o_res.continuation_mask = out_err ? '0 : continuation_mask;
    assign o_res.too_many          = out_err;
    assign o_res.last_result       = out_err | last_result;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_str.ready)
        else $error("input taken while results pending");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.too_many) |-> o_res.last_result)
        else $error("error word not final");

    a_slot_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.too_many) |-> o_res.occupied_mask[o_res.slot_number])
        else $error("result for unoccupied slot");
endmodule
